FILE: design/rpt_pkg.sv
package rpt_pkg;

	localparam int RPT_ENTRIES = 16;

	// opcodes
	localparam logic [2:0] OP_ADD     = 3'd0;
	localparam logic [2:0] OP_REMOVE  = 3'd1;
	localparam logic [2:0] OP_CLEAR   = 3'd2;
	localparam logic [2:0] OP_CHECK   = 3'd3;
	localparam logic [2:0] OP_SWEEP   = 3'd4;
	localparam logic [2:0] OP_USAGE   = 3'd5;
	localparam logic [2:0] OP_TICK    = 3'd6;
	localparam logic [2:0] OP_REFRESH = 3'd7;

	// status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_REFRESHED = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;
	localparam logic [1:0] ST_NOT_FOUND = 2'd3;

	// configuration register indexes
	localparam logic [1:0] REG_PERM_LIFETIME  = 2'd0;
	localparam logic [1:0] REG_ALLOC_LIFETIME = 2'd1;
	localparam logic [1:0] REG_BW_LIMIT       = 2'd2;
	localparam logic [1:0] REG_LOCAL_BYPASS   = 2'd3;

	localparam logic [31:0] PERM_LIFETIME_RST  = 32'd300;
	localparam logic [31:0] ALLOC_LIFETIME_RST = 32'd600;
	localparam logic [39:0] BW_LIMIT_RST       = 40'd0;
	localparam logic        LOCAL_BYPASS_RST   = 1'b1;

	localparam logic [39:0] UNLIMITED_REMAINING = 40'd99999999;
	localparam logic [15:0] PRIVATE_NET16       = 16'hC0A8;
	localparam logic [7:0]  LOOPBACK_NET8       = 8'd127;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [31:0] peer_address;
		logic [15:0] byte_count;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        permitted;
		logic        allocation_expired;
		logic [31:0] time_remaining;
		logic [39:0] bandwidth_remaining;
		logic [4:0]  entry_count;
	} out_item_t;

	typedef struct packed {
		logic [31:0] addr;
		logic [31:0] timer;
	} entry_t;

	// table sequencer -> allocation counters
	typedef struct packed {
		logic        add_bytes;
		logic        clr_age;
		logic        inc_age;
		logic [15:0] bytes;
	} alloc_cmd_t;

	typedef struct packed {
		logic        expired;
		logic [31:0] time_rem;
		logic [39:0] bw_rem;
	} alloc_stat_t;

	typedef struct packed {
		logic [1:0] status;
		logic       permitted;
		logic [4:0] entry_count;
	} table_res_t;

endpackage

FILE: design/rpt_entry_mem.sv
module rpt_entry_mem #(
	parameter int ENTRIES = rpt_pkg::RPT_ENTRIES,
	parameter int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  logic            clk,
	input  logic            rd_en,
	input  logic [IW-1:0]   rd_idx,
	output rpt_pkg::entry_t rd_data,
	input  logic            wr_en,
	input  logic [IW-1:0]   wr_idx,
	input  rpt_pkg::entry_t wr_data
);
	import rpt_pkg::*;

	entry_t mem_q [ENTRIES];
	entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_idx] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_idx];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: design/rpt_alloc.sv
module rpt_alloc (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [39:0]         cfg_data,
	input  rpt_pkg::alloc_cmd_t cmd,
	output logic [31:0]         perm_lifetime,
	output logic                bypass_en,
	output rpt_pkg::alloc_stat_t stat
);
	import rpt_pkg::*;

	logic [31:0] perm_life_q;
	logic [31:0] alloc_life_q;
	logic [39:0] bw_limit_q;
	logic        bypass_q;
	logic [39:0] bytes_used_q;
	logic [31:0] age_q;
	logic [40:0] bytes_sum;

	assign bytes_sum = {1'b0, bytes_used_q} + {25'd0, cmd.bytes};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			perm_life_q  <= PERM_LIFETIME_RST;
			alloc_life_q <= ALLOC_LIFETIME_RST;
			bw_limit_q   <= BW_LIMIT_RST;
			bypass_q     <= LOCAL_BYPASS_RST;
			bytes_used_q <= '0;
			age_q        <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_PERM_LIFETIME:  perm_life_q  <= cfg_data[31:0];
					REG_ALLOC_LIFETIME: alloc_life_q <= cfg_data[31:0];
					REG_BW_LIMIT:       bw_limit_q   <= cfg_data;
					REG_LOCAL_BYPASS:   bypass_q     <= cfg_data[0];
					default:            ;
				endcase
			end
			if (cmd.add_bytes) begin
				bytes_used_q <= bytes_sum[40] ? '1 : bytes_sum[39:0];
			end
			if (cmd.clr_age) begin
				age_q <= '0;
			end else if (cmd.inc_age && age_q != '1) begin
				age_q <= age_q + 32'd1;
			end
		end
	end

	always_comb begin
		stat.time_rem = (alloc_life_q > age_q) ? alloc_life_q - age_q : '0;
		if (bw_limit_q == '0) begin
			stat.bw_rem = UNLIMITED_REMAINING;
		end else begin
			stat.bw_rem = (bw_limit_q > bytes_used_q) ? bw_limit_q - bytes_used_q : '0;
		end
		stat.expired = (stat.time_rem == '0) || (stat.bw_rem == '0);
	end

	assign perm_lifetime = perm_life_q;
	assign bypass_en     = bypass_q;

endmodule

FILE: design/rpt_table_ctrl.sv
module rpt_table_ctrl #(
	parameter int ENTRIES = rpt_pkg::RPT_ENTRIES,
	parameter int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  rpt_pkg::in_item_t    req,
	input  logic [31:0]          perm_lifetime,
	input  logic                 bypass_en,
	output logic                 mem_rd_en,
	output logic [IW-1:0]        mem_rd_idx,
	input  rpt_pkg::entry_t      mem_rd_data,
	output logic                 mem_wr_en,
	output logic [IW-1:0]        mem_wr_idx,
	output rpt_pkg::entry_t      mem_wr_data,
	output rpt_pkg::alloc_cmd_t  alloc_cmd,
	input  logic                 out_free,
	output logic                 done,
	output rpt_pkg::table_res_t  res
);
	import rpt_pkg::*;

	localparam int CW   = $clog2(ENTRIES + 1);
	localparam int CNTW = $clog2(ENTRIES + 1);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_START  = 3'd1;
	localparam logic [2:0] S_SCAN   = 3'd2;
	localparam logic [2:0] S_COMMIT = 3'd3;
	localparam logic [2:0] S_FIN    = 3'd4;

	logic [2:0]         state_q;
	in_item_t           req_q;
	logic [CW-1:0]      iss_q;
	logic               vld_s1;
	logic [IW-1:0]      idx_s1;
	logic               hit_q;
	logic [IW-1:0]      hit_idx_q;
	logic               free_q;
	logic [IW-1:0]      free_idx_q;
	logic [ENTRIES-1:0] valid_q;
	logic [CNTW-1:0]    count_q;
	logic [1:0]         status_q;
	logic               permitted_q;

	logic issuing;
	logic scan_op;
	logic ent_valid;
	logic ent_match;
	logic is_local;

	assign req_ready = (state_q == S_IDLE);
	assign issuing   = (state_q == S_SCAN) && (iss_q < CW'(ENTRIES));
	assign scan_op   = req_q.opcode inside {OP_ADD, OP_REMOVE, OP_CHECK, OP_SWEEP, OP_TICK};
	assign ent_valid = vld_s1 && valid_q[idx_s1];
	assign ent_match = ent_valid && (mem_rd_data.addr == req_q.peer_address);
	assign is_local  = (req_q.peer_address[31:16] == PRIVATE_NET16) ||
		(req_q.peer_address[31:24] == LOOPBACK_NET8);

	assign mem_rd_en  = issuing;
	assign mem_rd_idx = iss_q[IW-1:0];

	always_comb begin
		mem_wr_en   = 1'b0;
		mem_wr_idx  = idx_s1;
		mem_wr_data = '{addr: mem_rd_data.addr, timer: mem_rd_data.timer - 32'd1};
		if (state_q == S_SCAN) begin
			// tick: count down live timers as they stream past
			mem_wr_en = ent_valid && (req_q.opcode == OP_TICK) && (mem_rd_data.timer != '0);
		end else if (state_q == S_COMMIT && req_q.opcode == OP_ADD) begin
			mem_wr_en   = hit_q || free_q;
			mem_wr_idx  = hit_q ? hit_idx_q : free_idx_q;
			mem_wr_data = '{addr: req_q.peer_address, timer: perm_lifetime};
		end
	end

	always_comb begin
		alloc_cmd.add_bytes = 1'b0;
		alloc_cmd.clr_age   = 1'b0;
		alloc_cmd.inc_age   = 1'b0;
		alloc_cmd.bytes     = req_q.byte_count;
		if (state_q == S_START) begin
			alloc_cmd.add_bytes = (req_q.opcode == OP_USAGE);
			alloc_cmd.clr_age   = (req_q.opcode == OP_USAGE) || (req_q.opcode == OP_REFRESH);
			alloc_cmd.inc_age   = (req_q.opcode == OP_TICK);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req_valid) begin
			req_q <= req;
		end
		idx_s1 <= iss_q[IW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			iss_q       <= '0;
			vld_s1      <= 1'b0;
			hit_q       <= 1'b0;
			hit_idx_q   <= '0;
			free_q      <= 1'b0;
			free_idx_q  <= '0;
			valid_q     <= '0;
			count_q     <= '0;
			status_q    <= ST_OK;
			permitted_q <= 1'b0;
		end else begin
			vld_s1 <= issuing;
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_START;
					end
				end
				S_START: begin
					iss_q       <= '0;
					hit_q       <= 1'b0;
					free_q      <= 1'b0;
					status_q    <= ST_OK;
					permitted_q <= 1'b0;
					if (req_q.opcode == OP_CLEAR) begin
						valid_q <= '0;
						count_q <= '0;
					end
					state_q <= scan_op ? S_SCAN : S_COMMIT;
				end
				S_SCAN: begin
					if (issuing) begin
						iss_q <= iss_q + CW'(1);
					end else begin
						// last read is being looked at this cycle
						state_q <= S_COMMIT;
					end
					if (ent_match && !hit_q) begin
						hit_q     <= 1'b1;
						hit_idx_q <= idx_s1;
					end
					if (vld_s1 && !valid_q[idx_s1] && !free_q) begin
						free_q     <= 1'b1;
						free_idx_q <= idx_s1;
					end
					if (ent_valid && req_q.opcode == OP_SWEEP && mem_rd_data.timer == '0) begin
						valid_q[idx_s1] <= 1'b0;
						count_q         <= count_q - CNTW'(1);
					end
				end
				S_COMMIT: begin
					case (req_q.opcode)
						OP_ADD: begin
							if (hit_q) begin
								status_q <= ST_REFRESHED;
							end else if (free_q) begin
								valid_q[free_idx_q] <= 1'b1;
								count_q             <= count_q + CNTW'(1);
							end else begin
								status_q <= ST_FULL;
							end
						end
						OP_REMOVE: begin
							if (hit_q) begin
								valid_q[hit_idx_q] <= 1'b0;
								count_q            <= count_q - CNTW'(1);
							end else begin
								status_q <= ST_NOT_FOUND;
							end
						end
						OP_CHECK: begin
							// bypass grants access but still reports not found
							status_q    <= hit_q ? ST_OK : ST_NOT_FOUND;
							permitted_q <= hit_q || (bypass_en && is_local);
						end
						default: ;
					endcase
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign done            = (state_q == S_FIN) && out_free;
	assign res.status      = status_q;
	assign res.permitted   = permitted_q;
	assign res.entry_count = 5'(count_q);

endmodule

FILE: design/relay_permission_table.sv
// channel  dir  handshake            payload
// req      in   req_valid/req_ready  in_item_t: opcode, peer_address, byte_count
// rsp      out  rsp_valid/rsp_ready  out_item_t: status .. entry_count
// cfg      in   cfg_we               cfg_index, cfg_data (no read-back)
//
// One request at a time. add, remove, check, sweep and tick walk the entry
// memory one read per cycle, passing through start, scan, commit and finish.
// clear, usage and refresh skip the scan: start, commit, finish.
// Reset clears the valid bits and allocation counters; no memory clearing pass.
// A stalled rsp holds the result; a new request is taken while it waits.
module relay_permission_table #(
	parameter int ENTRIES = rpt_pkg::RPT_ENTRIES
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  rpt_pkg::in_item_t  req,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output rpt_pkg::out_item_t rsp,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [39:0]        cfg_data
);
	import rpt_pkg::*;

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	logic        mem_rd_en;
	logic [IW-1:0] mem_rd_idx;
	entry_t      mem_rd_data;
	logic        mem_wr_en;
	logic [IW-1:0] mem_wr_idx;
	entry_t      mem_wr_data;
	alloc_cmd_t  alloc_cmd;
	alloc_stat_t alloc_stat;
	table_res_t  tbl_res;
	logic [31:0] perm_lifetime;
	logic        bypass_en;
	logic        done;
	logic        out_free;
	logic        rsp_valid_q;
	out_item_t   rsp_q;

	assign out_free = !rsp_valid_q || rsp_ready;

	rpt_entry_mem #(.ENTRIES(ENTRIES), .IW(IW)) u_mem (
		.clk     (clk),
		.rd_en   (mem_rd_en),
		.rd_idx  (mem_rd_idx),
		.rd_data (mem_rd_data),
		.wr_en   (mem_wr_en),
		.wr_idx  (mem_wr_idx),
		.wr_data (mem_wr_data)
	);

	rpt_alloc u_alloc (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.cmd           (alloc_cmd),
		.perm_lifetime (perm_lifetime),
		.bypass_en     (bypass_en),
		.stat          (alloc_stat)
	);

	rpt_table_ctrl #(.ENTRIES(ENTRIES), .IW(IW)) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_ready     (req_ready),
		.req           (req),
		.perm_lifetime (perm_lifetime),
		.bypass_en     (bypass_en),
		.mem_rd_en     (mem_rd_en),
		.mem_rd_idx    (mem_rd_idx),
		.mem_rd_data   (mem_rd_data),
		.mem_wr_en     (mem_wr_en),
		.mem_wr_idx    (mem_wr_idx),
		.mem_wr_data   (mem_wr_data),
		.alloc_cmd     (alloc_cmd),
		.out_free      (out_free),
		.done          (done),
		.res           (tbl_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (done) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			rsp_q.status              <= tbl_res.status;
			rsp_q.permitted           <= tbl_res.permitted;
			rsp_q.allocation_expired  <= alloc_stat.expired;
			rsp_q.time_remaining      <= alloc_stat.time_rem;
			rsp_q.bandwidth_remaining <= alloc_stat.bw_rem;
			rsp_q.entry_count         <= tbl_res.entry_count;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

FILE: tb/tb_relay_permission_table.sv
`timescale 1ns / 100ps

module tb_relay_permission_table;
	import rpt_pkg::*;

	localparam int QUIET_LIMIT = 5000;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 190;
	localparam int POOL        = 20;

	typedef struct packed {
		logic        cfg;        // register write instead of a request
		logic [1:0]  reg_idx;
		logic [39:0] reg_val;
		logic [2:0]  op;
		logic [31:0] addr;
		logic [15:0] bytes;
		logic [4:0]  reps;       // request repeated, address stepping by one
		logic        typed;
		out_item_t   answer;
	} plan_row_t;

	localparam int PLAN_ROWS = 32;
	localparam plan_row_t PLAN [PLAN_ROWS] = '{
		'{1'b0, REG_PERM_LIFETIME, 40'd0, OP_CHECK, 32'h7F00_0001, 16'd0, 5'd1, 1'b1,
		  '{ST_NOT_FOUND, 1'b1, 1'b0, ALLOC_LIFETIME_RST, UNLIMITED_REMAINING, 5'd0}},
		'{1'b0, REG_PERM_LIFETIME, 40'd0, OP_CHECK, 32'hC0A8_FFFF, 16'd0, 5'd1, 1'b1,
		  '{ST_NOT_FOUND, 1'b1, 1'b0, ALLOC_LIFETIME_RST, UNLIMITED_REMAINING, 5'd0}},
		'{1'b0, REG_PERM_LIFETIME, 40'd0, OP_CHECK, 32'hC0A9_0000, 16'd0, 5'd1, 1'b1,
		  '{ST_NOT_FOUND, 1'b0, 1'b0, ALLOC_LIFETIME_RST, UNLIMITED_REMAINING, 5'd0}},
		'{1'b0, REG_PERM_LIFETIME, 40'd0, OP_REMOVE, 32'hFFFF_FFFF, 16'd0, 5'd1, 1'b1,
		  '{ST_NOT_FOUND, 1'b0, 1'b0, ALLOC_LIFETIME_RST, UNLIMITED_REMAINING, 5'd0}},
		'{1'b0, REG_PERM_LIFETIME, 40'd0, OP_ADD, 32'h0000_0000, 16'd0, 5'd1, 1'b1,
		  '{ST_OK, 1'b0, 1'b0, ALLOC_LIFETIME_RST, UNLIMITED_REMAINING, 5'd1}},
		'{1'b0, REG_PERM_LIFETIME, 40'd0, OP_ADD, 32'hFFFF_FFFF, 16'd0, 5'd1, 1'b1,
		  '{ST_OK, 1'b0, 1'b0, ALLOC_LIFETIME_RST, UNLIMITED_REMAINING, 5'd2}},
		'{1'b0, REG_PERM_LIFETIME, 40'd0, OP_ADD, 32'h0000_0000, 16'd0, 5'd1, 1'b1,
		  '{ST_REFRESHED, 1'b0, 1'b0, ALLOC_LIFETIME_RST, UNLIMITED_REMAINING, 5'd2}},
		'{1'b0, REG_PERM_LIFETIME, 40'd0, OP_CHECK, 32'hFFFF_FFFF, 16'd0, 5'd1, 1'b1,
		  '{ST_OK, 1'b1, 1'b0, ALLOC_LIFETIME_RST, UNLIMITED_REMAINING, 5'd2}},
		'{1'b0, REG_PERM_LIFETIME, 40'd0, OP_USAGE, 32'h0, 16'hFFFF, 5'd1, 1'b0, '0},
		'{1'b0, REG_PERM_LIFETIME, 40'd0, OP_TICK, 32'h0, 16'd0, 5'd1, 1'b0, '0},
		'{1'b0, REG_PERM_LIFETIME, 40'd0, OP_SWEEP, 32'h0, 16'd0, 5'd1, 1'b0, '0},
		'{1'b0, REG_PERM_LIFETIME, 40'd0, OP_REFRESH, 32'h0, 16'd0, 5'd1, 1'b0, '0},
		'{1'b0, REG_PERM_LIFETIME, 40'd0, OP_REMOVE, 32'h0000_0000, 16'd0, 5'd1, 1'b1,
		  '{ST_OK, 1'b0, 1'b0, ALLOC_LIFETIME_RST, UNLIMITED_REMAINING, 5'd1}},
		'{1'b0, REG_PERM_LIFETIME, 40'd0, OP_CLEAR, 32'h0, 16'd0, 5'd1, 1'b1,
		  '{ST_OK, 1'b0, 1'b0, ALLOC_LIFETIME_RST, UNLIMITED_REMAINING, 5'd0}},
		// fill every slot, then one more add must be dropped
		'{1'b0, REG_PERM_LIFETIME, 40'd0, OP_ADD, 32'h0A00_0000, 16'd0, 5'd16, 1'b0, '0},
		'{1'b0, REG_PERM_LIFETIME, 40'd0, OP_ADD, 32'h0B00_0000, 16'd0, 5'd1, 1'b1,
		  '{ST_FULL, 1'b0, 1'b0, ALLOC_LIFETIME_RST, UNLIMITED_REMAINING, 5'd16}},
		'{1'b0, REG_PERM_LIFETIME, 40'd0, OP_CHECK, 32'h0A00_000F, 16'd0, 5'd1, 1'b0, '0},
		'{1'b0, REG_PERM_LIFETIME, 40'd0, OP_CLEAR, 32'h0, 16'd0, 5'd1, 1'b0, '0},
		// zero lifetime: entry is born expired and the sweep drops it
		'{1'b1, REG_PERM_LIFETIME, 40'd0, OP_ADD, 32'h0, 16'd0, 5'd0, 1'b0, '0},
		'{1'b0, REG_PERM_LIFETIME, 40'd0, OP_ADD, 32'h0102_0304, 16'd0, 5'd1, 1'b0, '0},
		'{1'b0, REG_PERM_LIFETIME, 40'd0, OP_SWEEP, 32'h0, 16'd0, 5'd1, 1'b0, '0},
		'{1'b1, REG_LOCAL_BYPASS, 40'd0, OP_ADD, 32'h0, 16'd0, 5'd0, 1'b0, '0},
		'{1'b0, REG_PERM_LIFETIME, 40'd0, OP_CHECK, 32'h7F00_0001, 16'd0, 5'd1, 1'b1,
		  '{ST_NOT_FOUND, 1'b0, 1'b0, ALLOC_LIFETIME_RST, UNLIMITED_REMAINING, 5'd0}},
		'{1'b1, REG_ALLOC_LIFETIME, 40'd0, OP_ADD, 32'h0, 16'd0, 5'd0, 1'b0, '0},
		'{1'b1, REG_BW_LIMIT, 40'd1, OP_ADD, 32'h0, 16'd0, 5'd0, 1'b0, '0},
		'{1'b0, REG_PERM_LIFETIME, 40'd0, OP_USAGE, 32'h0, 16'd0, 5'd1, 1'b0, '0},
		'{1'b0, REG_PERM_LIFETIME, 40'd0, OP_TICK, 32'h0, 16'd0, 5'd1, 1'b0, '0},
		'{1'b1, REG_BW_LIMIT, 40'hFF_FFFF_FFFF, OP_ADD, 32'h0, 16'd0, 5'd0, 1'b0, '0},
		'{1'b1, REG_PERM_LIFETIME, 40'hFF_FFFF_FFFF, OP_ADD, 32'h0, 16'd0, 5'd0, 1'b0, '0},
		'{1'b1, REG_ALLOC_LIFETIME, 40'hFF_FFFF_FFFF, OP_ADD, 32'h0, 16'd0, 5'd0, 1'b0, '0},
		'{1'b0, REG_PERM_LIFETIME, 40'd0, OP_ADD, 32'h7F00_0001, 16'd0, 5'd1, 1'b0, '0},
		'{1'b0, REG_PERM_LIFETIME, 40'd0, OP_TICK, 32'h0, 16'd0, 5'd1, 1'b0, '0}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_ready;
	in_item_t    req = '0;
	logic        rsp_valid;
	logic        rsp_ready = 1'b0;
	out_item_t   rsp;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = REG_PERM_LIFETIME;
	logic [39:0] cfg_data = '0;

	// mirror of the permission table and allocation counters
	logic        tbl_valid [RPT_ENTRIES];
	logic [31:0] tbl_addr  [RPT_ENTRIES];
	logic [31:0] tbl_timer [RPT_ENTRIES];
	logic [39:0] used_bytes = '0;
	logic [31:0] alloc_age = '0;
	logic [31:0] perm_life = PERM_LIFETIME_RST;
	logic [31:0] alloc_life = ALLOC_LIFETIME_RST;
	logic [39:0] bw_limit = BW_LIMIT_RST;
	logic        bypass_en = LOCAL_BYPASS_RST;

	out_item_t   expected_answers[$];
	out_item_t   want;
	logic [31:0] peer_pool [POOL];
	int          mismatches = 0;
	int          quiet_cycles = 0;
	int          burst_left = 0;
	int          gap;
	bit          steady = 1'b0;
	int          ready_mode = 0;
	int          ready_left = 0;

	relay_permission_table i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic out_item_t table_answer(input in_item_t it);
		out_item_t   a;
		int          hit;
		int          i;
		logic [40:0] sum;
		a = '0;
		a.status = ST_OK;
		hit = -1;
		for (i = 0; i < RPT_ENTRIES; i++)
			if (hit < 0 && tbl_valid[i] && tbl_addr[i] == it.peer_address)
				hit = i;
		case (it.opcode)
			OP_ADD: begin
				if (hit >= 0) begin
					tbl_timer[hit] = perm_life;
					a.status = ST_REFRESHED;
				end else begin
					a.status = ST_FULL;
					for (i = 0; i < RPT_ENTRIES; i++)
						if (a.status == ST_FULL && !tbl_valid[i]) begin
							tbl_valid[i] = 1'b1;
							tbl_addr[i] = it.peer_address;
							tbl_timer[i] = perm_life;
							a.status = ST_OK;
						end
				end
			end
			OP_REMOVE: begin
				if (hit >= 0)
					tbl_valid[hit] = 1'b0;
				else
					a.status = ST_NOT_FOUND;
			end
			OP_CLEAR: begin
				for (i = 0; i < RPT_ENTRIES; i++)
					tbl_valid[i] = 1'b0;
			end
			OP_CHECK: begin
				// expired entries still match until swept
				if (hit >= 0) begin
					a.permitted = 1'b1;
				end else begin
					a.status = ST_NOT_FOUND;
					a.permitted = bypass_en &&
						(it.peer_address[31:16] == PRIVATE_NET16 ||
						 it.peer_address[31:24] == LOOPBACK_NET8);
				end
			end
			OP_SWEEP: begin
				for (i = 0; i < RPT_ENTRIES; i++)
					if (tbl_valid[i] && tbl_timer[i] == 0)
						tbl_valid[i] = 1'b0;
			end
			OP_USAGE: begin
				sum = {1'b0, used_bytes} + {25'd0, it.byte_count};
				used_bytes = sum[40] ? '1 : sum[39:0];
				alloc_age = '0;
			end
			OP_TICK: begin
				for (i = 0; i < RPT_ENTRIES; i++)
					if (tbl_valid[i] && tbl_timer[i] != 0)
						tbl_timer[i] = tbl_timer[i] - 32'd1;
				if (alloc_age != '1)
					alloc_age = alloc_age + 32'd1;
			end
			default: begin
				alloc_age = '0;
			end
		endcase
		a.time_remaining = (alloc_life > alloc_age) ? alloc_life - alloc_age : '0;
		if (bw_limit != '0)
			a.bandwidth_remaining = (bw_limit > used_bytes) ? bw_limit - used_bytes : '0;
		else
			a.bandwidth_remaining = UNLIMITED_REMAINING;
		a.allocation_expired = (a.time_remaining == '0) || (a.bandwidth_remaining == '0);
		a.entry_count = '0;
		for (i = 0; i < RPT_ENTRIES; i++)
			if (tbl_valid[i])
				a.entry_count = a.entry_count + 5'd1;
		return a;
	endfunction

	function automatic string answer_text(input out_item_t a);
		return $sformatf("status=%0d permitted=%0d expired=%0d time=%0d bw=%0d entries=%0d",
			a.status, a.permitted, a.allocation_expired, a.time_remaining,
			a.bandwidth_remaining, a.entry_count);
	endfunction

	function automatic logic [39:0] pick_setting(input logic [1:0] idx);
		logic [39:0] v;
		int          pick;
		v = 40'({$urandom, $urandom});
		pick = $urandom_range(0, 4);
		case (idx)
			REG_PERM_LIFETIME: begin
				if (pick == 0) v = 40'd1;
				else if (pick == 1) v = 40'($urandom_range(1, 6));
				else if (pick == 2) v = 40'($urandom_range(20, 400));
				else if (pick == 3) v = 40'hFF_FFFF_FFFF;
			end
			REG_ALLOC_LIFETIME: begin
				if (pick == 0) v = 40'd0;
				else if (pick == 1) v = 40'($urandom_range(1, 40));
				else if (pick == 2) v = 40'(ALLOC_LIFETIME_RST);
				else if (pick == 3) v = 40'hFF_FFFF_FFFF;
			end
			REG_BW_LIMIT: begin
				if (pick == 0) v = 40'd0;
				else if (pick == 1) v = 40'($urandom_range(1, 300000));
				else if (pick == 2) v = used_bytes + 40'($urandom_range(0, 2000));
				else if (pick == 3) v = 40'hFF_FFFF_FFFF;
			end
			default: ;
		endcase
		return v;
	endfunction

	function automatic in_item_t random_request();
		in_item_t it;
		int       r;
		r = $urandom_range(0, 99);
		if (r < 30) it.opcode = OP_ADD;
		else if (r < 40) it.opcode = OP_REMOVE;
		else if (r < 42) it.opcode = OP_CLEAR;
		else if (r < 62) it.opcode = OP_CHECK;
		else if (r < 70) it.opcode = OP_SWEEP;
		else if (r < 80) it.opcode = OP_USAGE;
		else if (r < 93) it.opcode = OP_TICK;
		else it.opcode = OP_REFRESH;
		it.peer_address = ($urandom_range(0, 9) == 0) ? $urandom
			: peer_pool[$urandom_range(0, POOL - 1)];
		it.byte_count = ($urandom_range(0, 3) == 0) ? 16'($urandom)
			: 16'($urandom_range(0, 300));
		return it;
	endfunction

	// sender: bursts of back-to-back requests separated by random gaps
	task automatic idle_gap();
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 40);
			gap = steady ? 0 : $urandom_range(1, 24);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic issue(input in_item_t it, input bit typed, input out_item_t ans);
		out_item_t p;
		req <= it;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		p = table_answer(it);
		expected_answers.insert(expected_answers.size(), typed ? ans : p);
		idle_gap();
	endtask

	task automatic wait_quiet();
		req_valid <= 1'b0;
		while (expected_answers.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [39:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_PERM_LIFETIME:  perm_life = val[31:0];
			REG_ALLOC_LIFETIME: alloc_life = val[31:0];
			REG_BW_LIMIT:       bw_limit = val;
			REG_LOCAL_BYPASS:   bypass_en = val[0];
			default: ;
		endcase
	endtask

	// result checker and receiver stall pattern
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			if (expected_answers.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: %s", answer_text(rsp));
			end else begin
				want = expected_answers.pop_front();
				if (rsp.status !== want.status || rsp.permitted !== want.permitted ||
				    rsp.allocation_expired !== want.allocation_expired ||
				    rsp.time_remaining !== want.time_remaining ||
				    rsp.bandwidth_remaining !== want.bandwidth_remaining ||
				    rsp.entry_count !== want.entry_count) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %s\n          got      %s",
							answer_text(want), answer_text(rsp));
				end
			end
		end
		if (ready_left == 0) begin
			ready_mode = $urandom_range(0, 2);
			ready_left = $urandom_range(8, 150);
		end else begin
			ready_left--;
		end
		case (ready_mode)
			0:       rsp_ready <= 1'b1;
			1:       rsp_ready <= 1'($urandom_range(0, 1));
			default: rsp_ready <= ($urandom_range(0, 4) == 0);
		endcase
	end

	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			quiet_cycles = 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			quiet_cycles++;
		end
	end

	initial begin
		int       r;
		int       k;
		int       phase;
		int       i;
		in_item_t item;
		for (i = 0; i < RPT_ENTRIES; i++)
			tbl_valid[i] = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (r = 0; r < PLAN_ROWS; r++) begin
			if (PLAN[r].cfg) begin
				wait_quiet();
				write_reg(PLAN[r].reg_idx, PLAN[r].reg_val);
			end else begin
				for (k = 0; k < PLAN[r].reps; k++) begin
					item.opcode = PLAN[r].op;
					item.peer_address = PLAN[r].addr + 32'(k);
					item.byte_count = PLAN[r].bytes;
					issue(item, PLAN[r].typed, PLAN[r].answer);
				end
			end
		end

		for (phase = 0; phase < PHASES; phase++) begin
			wait_quiet();
			if ($urandom_range(0, 2) != 0)
				write_reg(REG_PERM_LIFETIME, pick_setting(REG_PERM_LIFETIME));
			if ($urandom_range(0, 2) != 0)
				write_reg(REG_ALLOC_LIFETIME, pick_setting(REG_ALLOC_LIFETIME));
			if ($urandom_range(0, 2) != 0)
				write_reg(REG_BW_LIMIT, pick_setting(REG_BW_LIMIT));
			if ($urandom_range(0, 1) != 0)
				write_reg(REG_LOCAL_BYPASS, pick_setting(REG_LOCAL_BYPASS));
			steady = (phase % 4 == 3);
			// small address pool so adds, removes and checks hit each other; locals
			// and near-local prefixes exercise the bypass decode
			for (i = 0; i < POOL; i++)
				case ($urandom_range(0, 4))
					0: peer_pool[i] = {LOOPBACK_NET8, 24'($urandom)};
					1: peer_pool[i] = {PRIVATE_NET16, 16'($urandom)};
					2: peer_pool[i] = {PRIVATE_NET16 ^ (16'd1 << $urandom_range(0, 15)),
						16'($urandom)};
					default: peer_pool[i] = $urandom;
				endcase
			repeat (PHASE_ITEMS)
				issue(random_request(), 1'b0, '0);
		end

		wait_quiet();
		repeat (RPT_ENTRIES + 8) @(posedge clk);
		if (mismatches == 0 && expected_answers.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
